FILE: hdl/mi_pkg.sv
// Shared types and codes for the modular inverse unit.
package mi_pkg;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MOD_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_COPRIME = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ALIGN,
        OP_UP,
        OP_DOWN,
        OP_SWAP,
        OP_FIX,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   coef;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic up_ok;
        logic rem_zero;
        logic gcd_one;
    } dp_stat_t;

endpackage

FILE: hdl/mi_datapath.sv
// Datapath of the modular inverse unit: remainders, coefficients, shifted divisor.
module mi_datapath #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mi_pkg::dp_cmd_t       cmd,
    input  logic [WORD_WIDTH-1:0] in_value,
    input  logic [WORD_WIDTH-1:0] in_modulus,
    output mi_pkg::dp_stat_t      stat,
    output logic [WORD_WIDTH-1:0] result
);
    import mi_pkg::*;

    localparam int W = WORD_WIDTH;

    logic [W-1:0] r0_reg, r1_reg, s0_reg, s1_reg, d_reg, sd_reg, mod_reg;
    logic         neg_reg;
    logic         ge;
    logic [W-1:0] diff;

    assign ge   = (r0_reg >= d_reg);
    assign diff = r0_reg - d_reg;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                r0_reg  <= in_value;
                r1_reg  <= in_modulus;
                mod_reg <= in_modulus;
                s0_reg  <= '0;
                s1_reg  <= W'(1);
                neg_reg <= 1'b0;
            end
            OP_ALIGN: begin
                d_reg  <= r1_reg;
                sd_reg <= s1_reg;
            end
            OP_UP: begin
                d_reg  <= {d_reg[W-2:0], 1'b0};
                sd_reg <= {sd_reg[W-2:0], 1'b0};
            end
            OP_DOWN: begin
                if (ge) begin
                    r0_reg <= diff;
                    if (cmd.coef) begin
                        s0_reg <= s0_reg + sd_reg;
                    end
                end
                d_reg  <= {1'b0, d_reg[W-1:1]};
                sd_reg <= {1'b0, sd_reg[W-1:1]};
            end
            OP_SWAP: begin
                r0_reg <= r1_reg;
                r1_reg <= r0_reg;
                if (cmd.coef) begin
                    s0_reg  <= s1_reg;
                    s1_reg  <= s0_reg;
                    neg_reg <= ~neg_reg;
                end
            end
            OP_FIX: begin
                if (s0_reg >= mod_reg) begin
                    s0_reg <= s0_reg - mod_reg;
                end
            end
            OP_FIN: begin
                if (!neg_reg && (s0_reg != '0)) begin
                    s0_reg <= mod_reg - s0_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.mod_zero = (mod_reg == '0);
    assign stat.up_ok    = ({d_reg, 1'b0} <= {1'b0, r0_reg});
    assign stat.rem_zero = (r1_reg == '0);
    assign stat.gcd_one  = (r0_reg == W'(1));
    assign result        = s0_reg;

    // Division never starts with a zero divisor.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_ALIGN |-> r1_reg != '0)
        else $error("divisor is zero at alignment");

    // The divisor is only doubled while it still fits the word.
    a_up_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_UP |-> !d_reg[W-1])
        else $error("divisor shift overflows");

    // The coefficient is reduced below the modulus before the sign fix.
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_FIN |-> s0_reg < mod_reg)
        else $error("coefficient not reduced");

endmodule

FILE: hdl/mi_ctrl.sv
// Sequencer of the modular inverse unit.
module mi_ctrl #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          out_free,
    input  mi_pkg::dp_stat_t              stat,
    output mi_pkg::dp_cmd_t               cmd,
    output logic                          emit,
    output logic [mi_pkg::STATUS_W-1:0]   emit_status
);
    import mi_pkg::*;

    localparam int KW = $clog2(WORD_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_INIT, S_UP, S_DOWN, S_SWAP, S_TEST, S_FIX, S_FIN, S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic                  reduce_reg, reduce_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        reduce_next = reduce_reg;
        status_next = status_reg;
        cmd.op      = OP_NONE;
        cmd.coef    = !reduce_reg;
        in_ready    = 1'b0;
        emit        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op      = OP_LOAD;
                    reduce_next = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.mod_zero) begin
                    status_next = ST_MOD_ZERO;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.op     = OP_ALIGN;
                k_next     = '0;
                state_next = S_UP;
            end
            S_UP: begin
                if (stat.up_ok) begin
                    cmd.op = OP_UP;
                    k_next = k_reg + KW'(1);
                end else begin
                    state_next = S_DOWN;
                end
            end
            S_DOWN: begin
                cmd.op = OP_DOWN;
                if (k_reg == '0) begin
                    state_next = S_SWAP;
                end else begin
                    k_next = k_reg - KW'(1);
                end
            end
            S_SWAP: begin
                cmd.op      = OP_SWAP;
                reduce_next = 1'b0;
                state_next  = S_TEST;
            end
            S_TEST: begin
                if (!stat.rem_zero) begin
                    state_next = S_INIT;
                end else if (stat.gcd_one) begin
                    state_next = S_FIX;
                end else begin
                    status_next = ST_NOT_COPRIME;
                    state_next  = S_EMIT;
                end
            end
            S_FIX: begin
                cmd.op     = OP_FIX;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.op      = OP_FIN;
                status_next = ST_OK;
                state_next  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign emit_status = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            reduce_reg <= 1'b0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            reduce_reg <= reduce_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: hdl/modular_inverse_unit_core.sv
// Top level of the modular inverse unit: stream ports, sequencer, datapath, result register.
//
// Computes the inverse of value modulo modulus by the extended Euclidean algorithm and returns
// it in 0..modulus-1 with a status (0 ok, 1 modulus zero, 2 value shares a factor with the
// modulus, value zero included); on an error the inverse is 0, and modulus one gives 0 with ok.
// One item is in work at a time. Each quotient is found by a shift-and-subtract divider: the
// divisor is doubled one bit a cycle until it would pass the remainder, then halved one bit a
// cycle while subtracting, with the Bezout coefficient updated alongside; each division is
// followed by a swap and a test of the remainders. The first division only reduces value below
// the modulus and leaves the coefficient alone. The work per item grows with the number of
// Euclid steps. The result sits in an output register, so the next transfer is taken while
// the previous result waits on m_tready.
module modular_inverse_unit_core #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // value, modulus (from bit 0 up), zero padded to whole bytes
    input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // inverse, zero padded to whole bytes
    output logic [((WORD_WIDTH+7)/8)*8-1:0]            m_tdata,
    // status
    output logic [mi_pkg::STATUS_W-1:0]                m_tuser
);
    import mi_pkg::*;

    localparam int W      = WORD_WIDTH;
    localparam int OUT_DW = ((W + 7) / 8) * 8;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [W-1:0]        dp_result;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                out_free;

    logic                m_valid_reg, m_valid_next;
    logic [W-1:0]        inverse_reg, inverse_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // The output register can take a new result when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_tready;

    mi_ctrl #(
        .WORD_WIDTH (W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .out_free    (out_free),
        .stat        (stat),
        .cmd         (cmd),
        .emit        (emit),
        .emit_status (emit_status)
    );

    mi_datapath #(
        .WORD_WIDTH (W)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   (s_tdata[W-1:0]),
        .in_modulus (s_tdata[2*W-1:W]),
        .stat       (stat),
        .result     (dp_result)
    );

    // Load a finished result; force the inverse to zero on any error status.
    always_comb begin
        m_valid_next = m_valid_reg;
        inverse_next = inverse_reg;
        status_next  = status_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            inverse_next = (emit_status == ST_OK) ? dp_result : '0;
            status_next  = emit_status;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inverse_reg <= inverse_next;
        status_reg  <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DW'(inverse_reg);
    assign m_tuser  = status_reg;

endmodule
